// File: design/fixed_block_pool_allocator_top_defines.svh
// Assertion macros for the fixed block pool allocator.
// Used by the top level; relies on aclk and aresetn being in scope.
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_TOP_DEFINES_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_TOP_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define FBPA_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// A consequence that must hold in the same cycle as its trigger.
`define FBPA_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// A consequence that must hold in the cycle after its trigger.
`define FBPA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/fbpa_pkg.sv
// Shared constants and codes for the fixed block pool allocator.
// Used by the divider and the top level; depends on nothing.
package fbpa_pkg;

    // Pool sizing.
    localparam int unsigned MAX_BLOCKS   = 256;
    localparam int unsigned HEADER_BYTES = 16;
    localparam int unsigned INDEX_W      = $clog2(MAX_BLOCKS);
    localparam int unsigned DEPTH_W      = $clog2(MAX_BLOCKS + 1);

    // Field widths.
    localparam int unsigned BYTES_W     = 16;
    localparam int unsigned COUNT_CFG_W = 9;
    localparam int unsigned REQ_W       = 24;
    localparam int unsigned OFFSET_W    = 25;
    localparam int unsigned STATUS_W    = 3;
    localparam int unsigned BLKNUM_W    = 8;
    localparam int unsigned STRIDE_W    = BYTES_W + 1;
    localparam int unsigned PROD_W      = INDEX_W + STRIDE_W;

    // Stream and configuration port widths.
    localparam int unsigned S_TDATA_W  = ((REQ_W + OFFSET_W + 7) / 8) * 8;
    localparam int unsigned M_TDATA_W  = ((OFFSET_W + BLKNUM_W + 7) / 8) * 8;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = BYTES_W;

    // Register indexes and reset values.
    localparam logic [CFG_IDX_W-1:0]   REG_BLOCK_BYTES = 1'd0;
    localparam logic [CFG_IDX_W-1:0]   REG_BLOCK_COUNT = 1'd1;
    localparam logic [BYTES_W-1:0]     BLOCK_BYTES_RST = 16'd64;
    localparam logic [COUNT_CFG_W-1:0] BLOCK_COUNT_RST = 9'd256;

    // Opcodes.
    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] ST_TOO_LARGE  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NO_BLOCKS  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_ADDR   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_IN_USE = 3'd4;

endpackage

// File: design/fixed_block_pool_allocator_top.sv
// Fixed block pool allocator: one request at a time, result held in an output register.
// An allocate passes through the check, a pop of the free stack when it holds a block, the mark
// and the finish states; a release passes the check, the 25-step serial divider, the in-use read
// if its offset is valid, then finish; a size, empty-pool or below-header error skips to finish.
// A request is taken only once the last result is registered; a waiting result holds the next.
// aresetn (synchronous, active low) restores defaults and empties the pool; a write also empties it.
`include "fixed_block_pool_allocator_top_defines.svh"

module fixed_block_pool_allocator_top (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Configuration write port.
    input  logic                             cfg_wr_en,
    input  logic [fbpa_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [fbpa_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    // Request channel.
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [fbpa_pkg::S_TDATA_W-1:0]   s_tdata,  // request_bytes[23:0], release_offset[48:24]
    input  logic                             s_tuser,  // opcode
    // Result channel.
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [fbpa_pkg::M_TDATA_W-1:0]   m_tdata,  // payload_offset[24:0], block_number[32:25]
    output logic [fbpa_pkg::STATUS_W-1:0]    m_tuser   // status
);

    localparam int unsigned INDEX_W  = fbpa_pkg::INDEX_W;
    localparam int unsigned DEPTH_W  = fbpa_pkg::DEPTH_W;
    localparam int unsigned OFFSET_W = fbpa_pkg::OFFSET_W;
    localparam int unsigned STRIDE_W = fbpa_pkg::STRIDE_W;
    localparam int unsigned PROD_W   = fbpa_pkg::PROD_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_POP,
        S_MARK,
        S_DIV,
        S_USE,
        S_FIN
    } state_t;

    state_t state_reg, state_next;

    logic                                op_reg, op_next;
    logic [fbpa_pkg::REQ_W-1:0]          req_reg, req_next;
    logic [OFFSET_W-1:0]                 addr_reg, addr_next;
    logic [INDEX_W-1:0]                  idx_reg, idx_next;
    logic [fbpa_pkg::STATUS_W-1:0]       status_reg, status_next;
    logic [PROD_W-1:0]                   prod_reg, prod_next;
    logic [DEPTH_W-1:0]                  freed_depth_reg, freed_depth_next;
    logic [DEPTH_W-1:0]                  fresh_next_reg, fresh_next_next;
    logic [fbpa_pkg::MAX_BLOCKS-1:0]     use_valid_reg, use_valid_next;
    logic [fbpa_pkg::BYTES_W-1:0]        block_bytes_reg, block_bytes_next;
    logic [fbpa_pkg::COUNT_CFG_W-1:0]    block_count_reg, block_count_next;
    logic                                m_tvalid_reg, m_tvalid_next;
    logic [fbpa_pkg::STATUS_W-1:0]       m_status_reg, m_status_next;
    logic [OFFSET_W-1:0]                 m_offset_reg, m_offset_next;
    logic [fbpa_pkg::BLKNUM_W-1:0]       m_blknum_reg, m_blknum_next;

    // Memory and divider controls.
    logic                 stk_wr_en, stk_rd_en;
    logic [INDEX_W-1:0]   stk_wr_addr, stk_wr_data, stk_rd_addr, stk_rd_data;
    logic                 use_wr_en, use_rd_en;
    logic [INDEX_W-1:0]   use_wr_addr, use_rd_addr;
    logic [0:0]           use_wr_data, use_rd_data;
    logic                 div_start, div_busy, div_done;
    logic [OFFSET_W-1:0]  div_quo;
    logic [STRIDE_W-1:0]  div_rem;

    logic [STRIDE_W-1:0]  stride;
    logic [DEPTH_W-1:0]   usable;
    logic [DEPTH_W-1:0]   depth_dec;
    logic                 in_use;
    logic                 push_ok;
    logic                 slot_free;

    // Free stack of released block indexes.
    fbpa_ram #(
        .DEPTH (fbpa_pkg::MAX_BLOCKS),
        .WIDTH (INDEX_W)
    ) u_stack (
        .aclk    (aclk),
        .wr_en   (stk_wr_en),
        .wr_addr (stk_wr_addr),
        .wr_data (stk_wr_data),
        .rd_en   (stk_rd_en),
        .rd_addr (stk_rd_addr),
        .rd_data (stk_rd_data)
    );

    // In-use flag per block; an entry without its valid bit reads as clear.
    fbpa_ram #(
        .DEPTH (fbpa_pkg::MAX_BLOCKS),
        .WIDTH (1)
    ) u_in_use (
        .aclk    (aclk),
        .wr_en   (use_wr_en),
        .wr_addr (use_wr_addr),
        .wr_data (use_wr_data),
        .rd_en   (use_rd_en),
        .rd_addr (use_rd_addr),
        .rd_data (use_rd_data)
    );

    // Offset to block index and remainder.
    fbpa_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (addr_reg - OFFSET_W'(fbpa_pkg::HEADER_BYTES)),
        .divisor   (stride),
        .busy      (div_busy),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // Derived pool figures.
    always_comb begin
        stride    = {1'b0, block_bytes_reg} + STRIDE_W'(fbpa_pkg::HEADER_BYTES);
        depth_dec = freed_depth_reg - 1'b1;
        in_use    = use_valid_reg[idx_reg] & use_rd_data[0];
        push_ok   = in_use && (freed_depth_reg < DEPTH_W'(fbpa_pkg::MAX_BLOCKS));
        slot_free = !m_tvalid_reg || m_tready;
        if (int'(block_count_reg) > fbpa_pkg::MAX_BLOCKS) begin
            usable = DEPTH_W'(fbpa_pkg::MAX_BLOCKS);
        end else begin
            usable = DEPTH_W'(block_count_reg);
        end
    end

    // Sequencer: read, modify and write back the pool state one request at a time.
    always_comb begin
        state_next       = state_reg;
        op_next          = op_reg;
        req_next         = req_reg;
        addr_next        = addr_reg;
        idx_next         = idx_reg;
        status_next      = status_reg;
        prod_next        = prod_reg;
        freed_depth_next = freed_depth_reg;
        fresh_next_next  = fresh_next_reg;
        use_valid_next   = use_valid_reg;
        block_bytes_next = block_bytes_reg;
        block_count_next = block_count_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        m_status_next    = m_status_reg;
        m_offset_next    = m_offset_reg;
        m_blknum_next    = m_blknum_reg;

        stk_wr_en   = 1'b0;
        stk_wr_addr = freed_depth_reg[INDEX_W-1:0];
        stk_wr_data = idx_reg;
        stk_rd_en   = 1'b0;
        stk_rd_addr = depth_dec[INDEX_W-1:0];
        use_wr_en   = 1'b0;
        use_wr_addr = idx_reg;
        use_wr_data = 1'b0;
        use_rd_en   = 1'b0;
        use_rd_addr = div_quo[INDEX_W-1:0];
        div_start   = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    op_next     = s_tuser;
                    req_next    = s_tdata[fbpa_pkg::REQ_W-1:0];
                    addr_next   = s_tdata[fbpa_pkg::REQ_W +: OFFSET_W];
                    status_next = fbpa_pkg::ST_OK;
                    state_next  = S_CHECK;
                end
            end
            S_CHECK: begin
                if (op_reg == fbpa_pkg::OP_ALLOC) begin
                    if (req_reg > fbpa_pkg::REQ_W'(block_bytes_reg)) begin
                        status_next = fbpa_pkg::ST_TOO_LARGE;
                        state_next  = S_FIN;
                    end else if (freed_depth_reg != '0) begin
                        stk_rd_en        = 1'b1;
                        freed_depth_next = depth_dec;
                        state_next       = S_POP;
                    end else if (fresh_next_reg < usable) begin
                        idx_next        = fresh_next_reg[INDEX_W-1:0];
                        fresh_next_next = fresh_next_reg + 1'b1;
                        state_next      = S_MARK;
                    end else begin
                        status_next = fbpa_pkg::ST_NO_BLOCKS;
                        state_next  = S_FIN;
                    end
                end else begin
                    if ((stride == '0) ||
                        (addr_reg < OFFSET_W'(fbpa_pkg::HEADER_BYTES))) begin
                        status_next = fbpa_pkg::ST_BAD_ADDR;
                        state_next  = S_FIN;
                    end else begin
                        div_start  = 1'b1;
                        state_next = S_DIV;
                    end
                end
            end
            S_POP: begin
                idx_next   = stk_rd_data;
                state_next = S_MARK;
            end
            S_MARK: begin
                // Claim the block and scale its index by the stride.
                use_wr_en               = 1'b1;
                use_wr_data             = 1'b1;
                use_valid_next[idx_reg] = 1'b1;
                prod_next  = PROD_W'(idx_reg) * PROD_W'(stride);
                state_next = S_FIN;
            end
            S_DIV: begin
                if (div_done) begin
                    if ((div_rem != '0) || (div_quo >= OFFSET_W'(usable))) begin
                        status_next = fbpa_pkg::ST_BAD_ADDR;
                        state_next  = S_FIN;
                    end else begin
                        idx_next   = div_quo[INDEX_W-1:0];
                        use_rd_en  = 1'b1;
                        state_next = S_USE;
                    end
                end
            end
            S_USE: begin
                // Release only a block in use, and push it on the free stack.
                if (!in_use) begin
                    status_next = fbpa_pkg::ST_NOT_IN_USE;
                end else if (push_ok) begin
                    use_wr_en        = 1'b1;
                    use_wr_data      = 1'b0;
                    stk_wr_en        = 1'b1;
                    freed_depth_next = freed_depth_reg + 1'b1;
                end else begin
                    status_next = fbpa_pkg::ST_BAD_ADDR;
                end
                state_next = S_FIN;
            end
            S_FIN: begin
                if (slot_free) begin
                    m_tvalid_next = 1'b1;
                    m_status_next = status_reg;
                    if (status_reg != fbpa_pkg::ST_OK) begin
                        m_offset_next = '0;
                        m_blknum_next = '0;
                    end else begin
                        m_blknum_next = fbpa_pkg::BLKNUM_W'(idx_reg);
                        if (op_reg == fbpa_pkg::OP_ALLOC) begin
                            m_offset_next =
                                OFFSET_W'(prod_reg + PROD_W'(fbpa_pkg::HEADER_BYTES));
                        end else begin
                            m_offset_next = addr_reg;
                        end
                    end
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // Register writes store the value and empty the pool.
        if (cfg_wr_en) begin
            unique case (cfg_index)
                fbpa_pkg::REG_BLOCK_BYTES: block_bytes_next = cfg_wdata;
                fbpa_pkg::REG_BLOCK_COUNT:
                    block_count_next = cfg_wdata[fbpa_pkg::COUNT_CFG_W-1:0];
                default: block_count_next = block_count_reg;
            endcase
            freed_depth_next = '0;
            fresh_next_next  = '0;
            use_valid_next   = '0;
        end
    end

    // State and registered outputs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            freed_depth_reg <= '0;
            fresh_next_reg  <= '0;
            use_valid_reg   <= '0;
            block_bytes_reg <= fbpa_pkg::BLOCK_BYTES_RST;
            block_count_reg <= fbpa_pkg::BLOCK_COUNT_RST;
            m_tvalid_reg    <= 1'b0;
        end else begin
            state_reg       <= state_next;
            freed_depth_reg <= freed_depth_next;
            fresh_next_reg  <= fresh_next_next;
            use_valid_reg   <= use_valid_next;
            block_bytes_reg <= block_bytes_next;
            block_count_reg <= block_count_next;
            m_tvalid_reg    <= m_tvalid_next;
        end
        op_reg       <= op_next;
        req_reg      <= req_next;
        addr_reg     <= addr_next;
        idx_reg      <= idx_next;
        status_reg   <= status_next;
        prod_reg     <= prod_next;
        m_status_reg <= m_status_next;
        m_offset_reg <= m_offset_next;
        m_blknum_reg <= m_blknum_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = fbpa_pkg::M_TDATA_W'({m_blknum_reg, m_offset_reg});

    // Checks on the pool bookkeeping.
    `FBPA_ASSERT_ALWAYS(a_depth_bound,
        freed_depth_reg <= DEPTH_W'(fbpa_pkg::MAX_BLOCKS), "free stack deeper than the pool")
    `FBPA_ASSERT_IMPLIES(a_idle_div, s_tready, !div_busy, "divider busy while taking a request")
    `FBPA_ASSERT_IMPLIES(a_err_zero, m_tvalid && (m_tuser != fbpa_pkg::ST_OK),
        m_tdata == '0, "error result carries data")
    `FBPA_ASSERT_NEXT(a_push, (state_reg == S_USE) && push_ok && !cfg_wr_en,
        freed_depth_reg == $past(freed_depth_reg) + 1'b1, "release did not push the stack")

endmodule

// File: design/fbpa_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Holds the free stack and the in-use flags of the block pool; no dependencies.
module fbpa_ram #(
    parameter int unsigned DEPTH = 256,
    parameter int unsigned WIDTH = 8
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port; the read data is registered.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: design/fbpa_div.sv
// Bit-serial restoring divider: payload offset over block stride.
// One quotient bit per cycle; uses widths from fbpa_pkg.
module fbpa_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [fbpa_pkg::OFFSET_W-1:0] dividend,
    input  logic [fbpa_pkg::STRIDE_W-1:0] divisor,
    output logic                          busy,
    output logic                          done,
    output logic [fbpa_pkg::OFFSET_W-1:0] quotient,
    output logic [fbpa_pkg::STRIDE_W-1:0] remainder
);

    localparam int unsigned CNT_W = $clog2(fbpa_pkg::OFFSET_W);

    logic [fbpa_pkg::STRIDE_W-1:0] rem_reg, rem_next;
    logic [fbpa_pkg::OFFSET_W-1:0] quo_reg, quo_next;
    logic [fbpa_pkg::STRIDE_W-1:0] dsr_reg, dsr_next;
    logic [CNT_W-1:0]              cnt_reg, cnt_next;
    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;

    logic [fbpa_pkg::STRIDE_W:0] trial;
    logic [fbpa_pkg::STRIDE_W:0] diff;
    logic                        fits;

    // One trial subtraction of the shifted partial remainder.
    always_comb begin
        trial = {rem_reg, quo_reg[fbpa_pkg::OFFSET_W-1]};
        diff  = trial - {1'b0, dsr_reg};
        fits  = (trial >= {1'b0, dsr_reg});
    end

    // Step sequencing.
    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = fits ? diff[fbpa_pkg::STRIDE_W-1:0] : trial[fbpa_pkg::STRIDE_W-1:0];
            quo_next = {quo_reg[fbpa_pkg::OFFSET_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(fbpa_pkg::OFFSET_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign busy      = busy_reg;
    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// File: bench/fixed_block_pool_allocator_top_test.sv
// Self-checking bench for the fixed block pool allocator: directed table, then random phases.
// Predicts every status, payload offset and block number; depends on fbpa_pkg and the top level.
module fixed_block_pool_allocator_top_test;
    import fbpa_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 1000000;
    localparam int unsigned TAIL_CYCLES = 40;
    localparam int unsigned REPORT_MAX  = 10;
    localparam int unsigned RANGE_TOP   = 16781055;

    // One answer of the allocator, as it leaves the result channel.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [OFFSET_W-1:0] offset;
        logic [BLKNUM_W-1:0] block;
    } alloc_result_t;

    typedef enum logic {ROW_REQUEST, ROW_SETUP} row_kind_e;

    // For a request row a is request_bytes and b is release_offset;
    // for a setup row a is block_bytes and b is block_count.
    typedef struct {
        row_kind_e     kind;
        logic          op;
        int unsigned   a;
        int unsigned   b;
        bit            typed;
        alloc_result_t want;
    } plan_row_t;

    typedef struct {
        int unsigned bytes_val;
        int unsigned count_val;
        int unsigned items;
        int unsigned alloc_pct;
        int unsigned send_pct;
        int unsigned recv_pct;
    } phase_t;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_BLOCK_BYTES;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  s_tuser   = OP_ALLOC;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [STATUS_W-1:0]   m_tuser;

    // Predicted pool state and configuration.
    logic [BYTES_W-1:0]     pool_bytes  = BLOCK_BYTES_RST;
    logic [COUNT_CFG_W-1:0] pool_count  = BLOCK_COUNT_RST;
    logic [INDEX_W-1:0]     freed_stack [MAX_BLOCKS];
    logic [DEPTH_W-1:0]     freed_depth = '0;
    logic [DEPTH_W-1:0]     fresh_next  = '0;
    bit                     in_use      [MAX_BLOCKS];

    alloc_result_t expected_results [$];
    alloc_result_t got_result;
    alloc_result_t want_result;
    int unsigned   mismatch_count = 0;
    int unsigned   cycle_count    = 0;
    int unsigned   send_idle_pct  = 21;
    int unsigned   recv_idle_pct  = 69;

    // Directed table, default configuration first (stride 80).
    plan_row_t plan [] = '{
        '{ROW_REQUEST, OP_ALLOC,   0,        0,        1'b1, '{ST_OK, 25'd16, 8'd0}},
        '{ROW_REQUEST, OP_ALLOC,   64,       0,        1'b1, '{ST_OK, 25'd96, 8'd1}},
        '{ROW_REQUEST, OP_ALLOC,   65,       0,        1'b1, '{ST_TOO_LARGE, 25'd0, 8'd0}},
        '{ROW_REQUEST, OP_ALLOC,   24'hFFFFFF, 0,      1'b1, '{ST_TOO_LARGE, 25'd0, 8'd0}},
        '{ROW_REQUEST, OP_RELEASE, 0,        16,       1'b1, '{ST_OK, 25'd16, 8'd0}},
        '{ROW_REQUEST, OP_RELEASE, 0,        16,       1'b1, '{ST_NOT_IN_USE, 25'd0, 8'd0}},
        '{ROW_REQUEST, OP_ALLOC,   10,       0,        1'b0, '{ST_OK, 25'd0, 8'd0}},
        '{ROW_REQUEST, OP_RELEASE, 0,        0,        1'b1, '{ST_BAD_ADDR, 25'd0, 8'd0}},
        '{ROW_REQUEST, OP_RELEASE, 0,        15,       1'b1, '{ST_BAD_ADDR, 25'd0, 8'd0}},
        '{ROW_REQUEST, OP_RELEASE, 0,        97,       1'b1, '{ST_BAD_ADDR, 25'd0, 8'd0}},
        '{ROW_REQUEST, OP_RELEASE, 0,        20496,    1'b1, '{ST_BAD_ADDR, 25'd0, 8'd0}},
        '{ROW_REQUEST, OP_RELEASE, 0,        20416,    1'b1, '{ST_NOT_IN_USE, 25'd0, 8'd0}},
        '{ROW_REQUEST, OP_RELEASE, 0,        RANGE_TOP, 1'b1, '{ST_BAD_ADDR, 25'd0, 8'd0}},
        '{ROW_REQUEST, OP_RELEASE, 0,        96,       1'b0, '{ST_OK, 25'd0, 8'd0}},
        '{ROW_SETUP,   OP_ALLOC,   64,       1,        1'b0, '{ST_OK, 25'd0, 8'd0}},
        '{ROW_REQUEST, OP_ALLOC,   0,        0,        1'b1, '{ST_OK, 25'd16, 8'd0}},
        '{ROW_REQUEST, OP_ALLOC,   0,        0,        1'b1, '{ST_NO_BLOCKS, 25'd0, 8'd0}},
        '{ROW_REQUEST, OP_RELEASE, 0,        96,       1'b1, '{ST_BAD_ADDR, 25'd0, 8'd0}},
        '{ROW_SETUP,   OP_ALLOC,   64,       0,        1'b0, '{ST_OK, 25'd0, 8'd0}},
        '{ROW_REQUEST, OP_ALLOC,   0,        0,        1'b1, '{ST_NO_BLOCKS, 25'd0, 8'd0}},
        '{ROW_REQUEST, OP_RELEASE, 0,        16,       1'b1, '{ST_BAD_ADDR, 25'd0, 8'd0}},
        '{ROW_SETUP,   OP_ALLOC,   0,        2,        1'b0, '{ST_OK, 25'd0, 8'd0}},
        '{ROW_REQUEST, OP_ALLOC,   1,        0,        1'b1, '{ST_TOO_LARGE, 25'd0, 8'd0}},
        '{ROW_REQUEST, OP_ALLOC,   0,        0,        1'b1, '{ST_OK, 25'd16, 8'd0}},
        '{ROW_REQUEST, OP_ALLOC,   0,        0,        1'b0, '{ST_OK, 25'd0, 8'd0}},
        '{ROW_SETUP,   OP_ALLOC,   65535,    511,      1'b0, '{ST_OK, 25'd0, 8'd0}},
        '{ROW_REQUEST, OP_ALLOC,   65535,    0,        1'b1, '{ST_OK, 25'd16, 8'd0}},
        '{ROW_REQUEST, OP_ALLOC,   65536,    0,        1'b1, '{ST_TOO_LARGE, 25'd0, 8'd0}}
    };

    // Random phases: configuration, length, mix and idling.
    phase_t phases [] = '{
        '{64,    256, 300, 55, 21, 69},
        '{0,     3,   100, 50, 21, 69},
        '{65535, 511, 350, 60, 69, 21},
        '{1,     1,   100, 45, 69, 21},
        '{200,   300, 400, 70, 0,  0},
        '{65534, 0,   50,  50, 0,  0},
        '{37,    17,  450, 50, 0,  0}
    };

    fixed_block_pool_allocator_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // Clock generation.
    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Predicts the answer to one request and advances the predicted pool.
    function automatic alloc_result_t pool_answer(input logic op, input logic [REQ_W-1:0] req,
                                                  input logic [OFFSET_W-1:0] rel);
        alloc_result_t   res;
        int unsigned     usable;
        int unsigned     idx;
        longint unsigned stride;
        longint unsigned span;
        longint unsigned slot;
        res.status = ST_OK;
        res.offset = '0;
        res.block  = '0;
        idx        = 0;
        usable     = (pool_count > MAX_BLOCKS) ? MAX_BLOCKS : pool_count;
        stride     = longint'(pool_bytes) + HEADER_BYTES;
        if (op == OP_ALLOC) begin
            // Size check, then the last released block, then the lowest fresh one.
            if (req > pool_bytes) begin
                res.status = ST_TOO_LARGE;
            end else if (freed_depth > 0) begin
                freed_depth = freed_depth - 1'b1;
                idx = freed_stack[freed_depth];
            end else if (fresh_next < usable) begin
                idx = fresh_next;
                fresh_next = fresh_next + 1'b1;
            end else begin
                res.status = ST_NO_BLOCKS;
            end
            if (res.status == ST_OK) begin
                in_use[idx] = 1'b1;
                res.offset  = OFFSET_W'(idx * stride + HEADER_BYTES);
                res.block   = BLKNUM_W'(idx);
            end
        end else begin
            // The offset must sit on a payload boundary of a block inside the pool.
            res.status = ST_BAD_ADDR;
            if (stride != 0 && rel >= HEADER_BYTES) begin
                span = rel - HEADER_BYTES;
                slot = span / stride;
                if (span % stride == 0 && slot < usable) begin
                    idx = int'(slot);
                    if (!in_use[idx]) begin
                        res.status = ST_NOT_IN_USE;
                    end else if (freed_depth < MAX_BLOCKS) begin
                        in_use[idx] = 1'b0;
                        freed_stack[freed_depth] = INDEX_W'(idx);
                        freed_depth = freed_depth + 1'b1;
                        res.status  = ST_OK;
                        res.offset  = rel;
                        res.block   = BLKNUM_W'(idx);
                    end
                end
            end
        end
        return res;
    endfunction

    // Offers one request, waits for it to be taken and records what it should answer.
    task automatic push_request(input logic op, input int unsigned req, input int unsigned rel,
                                input bit typed, input alloc_result_t typed_want);
        alloc_result_t predicted;
        if ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{(S_TDATA_W - REQ_W - OFFSET_W){1'b0}}, OFFSET_W'(rel), REQ_W'(req)};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predicted = pool_answer(op, REQ_W'(req), OFFSET_W'(rel));
        expected_results.push_back(typed ? typed_want : predicted);
    endtask

    // Holds the request channel off until every outstanding answer has arrived.
    task automatic settle_pool();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
    endtask

    // Writes both registers; each write empties the pool.
    task automatic program_pool(input int unsigned bytes_val, input int unsigned count_val);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_BLOCK_BYTES;
        cfg_wdata <= CFG_DATA_W'(bytes_val);
        @(posedge aclk);
        cfg_index <= REG_BLOCK_COUNT;
        cfg_wdata <= CFG_DATA_W'(COUNT_CFG_W'(count_val));
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        pool_bytes  = BYTES_W'(bytes_val);
        pool_count  = COUNT_CFG_W'(count_val);
        freed_depth = '0;
        fresh_next  = '0;
        foreach (in_use[i]) in_use[i] = 1'b0;
    endtask

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Result side: check each answer against the oldest expected answer, then stall at random.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_result.status = m_tuser;
            got_result.offset = m_tdata[OFFSET_W-1:0];
            got_result.block  = m_tdata[OFFSET_W +: BLKNUM_W];
            if (expected_results.size() == 0) begin
                mismatch_count = mismatch_count + 1;
                if (mismatch_count <= REPORT_MAX) begin
                    $display("unexpected answer: status %0d offset %0d block %0d",
                             got_result.status, got_result.offset, got_result.block);
                end
            end else begin
                want_result = expected_results.pop_front();
                if (got_result.status !== want_result.status ||
                    got_result.offset !== want_result.offset ||
                    got_result.block  !== want_result.block) begin
                    mismatch_count = mismatch_count + 1;
                    if (mismatch_count <= REPORT_MAX) begin
                        $display("answer differs: status %0d/%0d offset %0d/%0d block %0d/%0d",
                                 want_result.status, got_result.status,
                                 want_result.offset, got_result.offset,
                                 want_result.block, got_result.block);
                    end
                end
            end
        end
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Stimulus: reset, directed table, then the random phases.
    initial begin
        int unsigned usable;
        int unsigned roll;
        int unsigned req;
        int unsigned rel;
        int unsigned pick;
        int          live [$];
        foreach (freed_stack[i]) freed_stack[i] = '0;
        foreach (in_use[i]) in_use[i] = 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (plan[r]) begin
            if (plan[r].kind == ROW_SETUP) begin
                settle_pool();
                program_pool(plan[r].a, plan[r].b);
            end else begin
                push_request(plan[r].op, plan[r].a, plan[r].b, plan[r].typed, plan[r].want);
            end
        end

        foreach (phases[p]) begin
            settle_pool();
            send_idle_pct = phases[p].send_pct;
            recv_idle_pct = phases[p].recv_pct;
            program_pool(phases[p].bytes_val, phases[p].count_val);
            for (int n = 0; n < phases[p].items; n++) begin
                // Halfway through, let the pool go quiet once.
                if (n == phases[p].items / 2) settle_pool();
                usable = (pool_count > MAX_BLOCKS) ? MAX_BLOCKS : pool_count;
                live.delete();
                for (int b = 0; b < usable; b++) begin
                    if (in_use[b]) live.push_back(b);
                end
                roll = $urandom_range(0, 99);
                if (roll < phases[p].alloc_pct || (roll < 88 && live.size() == 0)) begin
                    // Well-formed allocate, with the size extremes now and then.
                    case ($urandom_range(0, 9))
                        0: req = 0;
                        1: req = pool_bytes;
                        default: req = $urandom_range(0, pool_bytes);
                    endcase
                    push_request(OP_ALLOC, req, $urandom_range(0, RANGE_TOP), 1'b0, '0);
                end else if (roll < 88) begin
                    // Well-formed release of a block currently handed out.
                    pick = live[$urandom_range(0, live.size() - 1)];
                    rel  = pick * (pool_bytes + HEADER_BYTES) + HEADER_BYTES;
                    push_request(OP_RELEASE, $urandom & 24'hFFFFFF, rel, 1'b0, '0);
                end else begin
                    // Noise: oversize, stray offsets, boundaries of idle or missing blocks.
                    case ($urandom_range(0, 4))
                        0: push_request(OP_ALLOC, pool_bytes + 1 +
                                        $urandom_range(0, 24'hFFFFFF - pool_bytes - 1),
                                        0, 1'b0, '0);
                        1: push_request(OP_RELEASE, 0, $urandom_range(0, RANGE_TOP), 1'b0, '0);
                        2: push_request(OP_RELEASE, 0,
                                        $urandom_range(0, usable) *
                                        (pool_bytes + HEADER_BYTES) + HEADER_BYTES, 1'b0, '0);
                        3: push_request(OP_RELEASE, 0,
                                        $urandom_range(0, usable) *
                                        (pool_bytes + HEADER_BYTES) + HEADER_BYTES +
                                        $urandom_range(0, 1) * 2 - 1, 1'b0, '0);
                        default: push_request(OP_ALLOC, $urandom & 24'hFFFFFF, 0, 1'b0, '0);
                    endcase
                end
            end
        end

        // Drain, then give a late stray answer the chance to show up.
        settle_pool();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
